// ===== rtl/med_pkg.sv =====
// ----------------------------------------------------------------------------
// med_pkg
// Shared types, constants and the median edge prediction function of the
// predictive pixel codec.
// ----------------------------------------------------------------------------
package med_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 4096;

  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0]  REG_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  REG_WIDTH = 1'b1;

  localparam logic                  MODE_ENCODE = 1'b0;
  localparam logic                  MODE_DECODE = 1'b1;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET = 13'd256;

  localparam logic [7:0]            ALPHA_ENCODE = 8'h00;
  localparam logic [7:0]            ALPHA_DECODE = 8'hFF;

  typedef struct packed {
    logic       start_of_image;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pixel_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  function automatic logic [7:0] med_pred(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c > hi) begin
      med_pred = lo;
    end else if (c < lo) begin
      med_pred = hi;
    end else begin
      med_pred = a + b - c;
    end
  endfunction

endpackage

// ===== rtl/med_row_mem.sv =====
// ----------------------------------------------------------------------------
// med_row_mem
// Row store holding the reconstructed previous row: one write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
module med_row_mem #(
  parameter int unsigned DEPTH = med_pkg::MAX_WIDTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  med_pkg::rgb_t     wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output med_pkg::rgb_t     rd_data
);

  med_pkg::rgb_t mem [DEPTH];
  med_pkg::rgb_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/med_pred_dp.sv =====
// ----------------------------------------------------------------------------
// med_pred_dp
// Per-channel median edge prediction followed by residual forming (encode)
// or reconstruction (decode).
// ----------------------------------------------------------------------------
module med_pred_dp (
  input  med_pkg::pixel_in_t  pix,
  input  med_pkg::rgb_t       left,
  input  med_pkg::rgb_t       top,
  input  med_pkg::rgb_t       upper_left,
  input  logic                mode,
  output med_pkg::pixel_out_t result,
  output med_pkg::rgb_t       recon
);

  med_pkg::rgb_t pred;
  med_pkg::rgb_t sum;
  med_pkg::rgb_t diff;

  always_comb begin
    pred.red   = med_pkg::med_pred(left.red,   top.red,   upper_left.red);
    pred.green = med_pkg::med_pred(left.green, top.green, upper_left.green);
    pred.blue  = med_pkg::med_pred(left.blue,  top.blue,  upper_left.blue);

    sum.red    = pix.in_red   + pred.red;
    sum.green  = pix.in_green + pred.green;
    sum.blue   = pix.in_blue  + pred.blue;
    diff.red   = pix.in_red   - pred.red;
    diff.green = pix.in_green - pred.green;
    diff.blue  = pix.in_blue  - pred.blue;

    if (mode == med_pkg::MODE_DECODE) begin
      result.out_red   = sum.red;
      result.out_green = sum.green;
      result.out_blue  = sum.blue;
      result.out_alpha = med_pkg::ALPHA_DECODE;
      recon            = sum;
    end else begin
      result.out_red   = diff.red;
      result.out_green = diff.green;
      result.out_blue  = diff.blue;
      result.out_alpha = med_pkg::ALPHA_ENCODE;
      recon.red        = pix.in_red;
      recon.green      = pix.in_green;
      recon.blue       = pix.in_blue;
    end
  end

endmodule

// ===== rtl/med_predictive_pixel_codec.sv =====
// ----------------------------------------------------------------------------
// med_predictive_pixel_codec
// Median edge predictive pixel codec: raster-order RGB pixels in, residuals
// (encode) or reconstructed pixels (decode) out, with a row store for the
// previous row.
// ----------------------------------------------------------------------------
// An accepted input is registered in the first stage, its result in the output
// register. Throughput: one transaction per cycle while out_stall is low; the
// row store is read on acceptance and written when the result is registered.
// Reset: synchronous, active low; mode returns to encode, the width to 256 and
// the position to the first pixel of an image. The row store is not cleared.
module med_predictive_pixel_codec #(
  parameter int unsigned MAX_WIDTH = med_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  med_pkg::pixel_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output med_pkg::pixel_out_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [med_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [med_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW = (AW + 1 > med_pkg::CFG_DATA_W) ? AW + 1 : med_pkg::CFG_DATA_W;

  logic                           mode_r;
  logic [med_pkg::CFG_DATA_W-1:0] width_r;

  logic [AW-1:0]       column_r;
  logic [AW-1:0]       column_nxt;
  logic                first_row_r;
  logic                first_row_nxt;

  logic                s1_valid_r;
  logic                s1_valid_nxt;
  med_pkg::pixel_in_t  s1_pix_r;
  logic [AW-1:0]       s1_col_r;
  logic                s1_first_r;
  logic                fwd_r;
  med_pkg::rgb_t       fwd_data_r;

  med_pkg::rgb_t       left_r;
  med_pkg::rgb_t       upper_left_r;

  logic                out_valid_r;
  med_pkg::pixel_out_t out_data_r;

  logic                in_accept;
  logic                s1_go;
  logic                s1_move;
  logic [CW-1:0]       width_ext;
  logic [CW-1:0]       width_eff;
  logic [CW-1:0]       col_ext;
  logic [CW-1:0]       col_inc;
  logic [AW-1:0]       col_eff;
  logic                first_eff;
  logic                restart;

  med_pkg::rgb_t       rd_data;
  med_pkg::rgb_t       top_raw;
  med_pkg::rgb_t       top_eff;
  med_pkg::rgb_t       left_eff;
  med_pkg::rgb_t       ul_eff;
  med_pkg::rgb_t       recon;
  med_pkg::pixel_out_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= med_pkg::MODE_ENCODE;
      width_r <= med_pkg::WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        med_pkg::REG_MODE:  mode_r  <= cfg_data[0];
        med_pkg::REG_WIDTH: width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_go     = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && s1_go;
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    width_ext = CW'(width_r);
    if (width_ext == '0) begin
      width_eff = CW'(1);
    end else if (width_ext > CW'(MAX_WIDTH)) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end

    col_ext   = CW'(column_r);
    restart   = in_data.start_of_image || (col_ext >= width_eff);
    col_eff   = restart ? '0 : column_r;
    first_eff = in_data.start_of_image ? 1'b1 :
                ((col_ext >= width_eff) ? 1'b0 : first_row_r);
    col_inc   = CW'(col_eff) + CW'(1);

    if (col_inc >= width_eff) begin
      column_nxt    = '0;
      first_row_nxt = 1'b0;
    end else begin
      column_nxt    = col_inc[AW-1:0];
      first_row_nxt = first_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r    <= '0;
      first_row_r <= 1'b1;
    end else if (in_accept) begin
      column_r    <= column_nxt;
      first_row_r <= first_row_nxt;
    end
  end

  assign s1_valid_nxt = in_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix_r   <= in_data;
      s1_col_r   <= col_eff;
      s1_first_r <= first_eff;
      fwd_r      <= s1_move && (s1_col_r == col_eff);
      fwd_data_r <= recon;
    end
  end

  med_row_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_row_mem (
    .clk     (clk),
    .wr_en   (s1_move),
    .wr_addr (s1_col_r),
    .wr_data (recon),
    .rd_en   (in_accept),
    .rd_addr (col_eff),
    .rd_data (rd_data)
  );

  always_comb begin
    top_raw  = fwd_r ? fwd_data_r : rd_data;
    top_eff  = s1_first_r ? '0 : top_raw;
    left_eff = (s1_col_r == '0) ? '0 : left_r;
    ul_eff   = (s1_col_r == '0) ? '0 : upper_left_r;
  end

  med_pred_dp u_pred_dp (
    .pix        (s1_pix_r),
    .left       (left_eff),
    .top        (top_eff),
    .upper_left (ul_eff),
    .mode       (mode_r),
    .result     (result),
    .recon      (recon)
  );

  always_ff @(posedge clk) begin
    if (s1_move) begin
      left_r       <= recon;
      upper_left_r <= top_eff;
      out_data_r   <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_needs_item : assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with an empty first stage");

  a_accept_fills_stage : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted transaction did not reach the first stage");

  a_fwd_only_col_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && fwd_r) |-> (s1_col_r == '0))
    else $error("row store bypass used away from the first column");

  a_move_fills_output : assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("result lost between first stage and output register");

endmodule

// ===== bench/tb_med_predictive_pixel_codec.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_med_predictive_pixel_codec
// Self-checking bench for the median edge predictive pixel codec. A short
// table of directed pixels and register writes comes first, then random
// images in both coding modes over many row widths. Each result is checked against
// its table entry or a behavioural predictor; idling is random but in the last phase.
// ----------------------------------------------------------------------------
module tb_med_predictive_pixel_codec;

  localparam int RAND_PER_PHASE = 250;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;

  typedef struct {
    bit                             is_cfg;
    bit                             wr_mode;
    logic                           mode_val;
    bit                             wr_width;
    logic [med_pkg::CFG_DATA_W-1:0] width_val;
    med_pkg::pixel_in_t             px;
    bit                             typed;
    med_pkg::pixel_out_t            want;
  } script_row_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  med_pkg::pixel_in_t             in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  med_pkg::pixel_out_t            out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [med_pkg::CFG_IDX_W-1:0]  cfg_index = med_pkg::REG_MODE;
  logic [med_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // Predictor state and its copy of the registers.
  med_pkg::rgb_t                  prev_row       [med_pkg::MAX_WIDTH_DEF];
  bit                             prev_row_valid [med_pkg::MAX_WIDTH_DEF];
  med_pkg::rgb_t                  left_rgb       = '0;
  med_pkg::rgb_t                  upleft_rgb     = '0;
  int                             col_pos        = 0;
  bit                             first_row      = 1'b1;
  logic                           cur_mode       = med_pkg::MODE_ENCODE;
  logic [med_pkg::CFG_DATA_W-1:0] cur_width      = med_pkg::WIDTH_RESET;

  med_pkg::pixel_out_t            pending_px_q [$];
  med_pkg::pixel_out_t            head_px;
  script_row_t                    script_q [$];
  int                             in_idle_pct   = 17;
  int                             out_stall_pct = 87;
  int                             px_sent       = 0;
  int                             px_checked    = 0;
  int                             cfg_writes    = 0;
  int                             mismatch_cnt  = 0;
  int                             idle_cycles   = 0;

  med_predictive_pixel_codec u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] med_estimate(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
    logic [7:0] small_ab;
    logic [7:0] big_ab;
    small_ab = (b < a) ? b : a;
    big_ab   = (b < a) ? a : b;
    if (c > big_ab) begin
      return small_ab;
    end
    if (c < small_ab) begin
      return big_ab;
    end
    return a + b - c;
  endfunction

  function automatic int eff_width();
    if (cur_width == 0) begin
      return 1;
    end
    if (cur_width > med_pkg::MAX_WIDTH_DEF) begin
      return med_pkg::MAX_WIDTH_DEF;
    end
    return int'(cur_width);
  endfunction

  // True when a pixel without a start flag would read a row entry never written.
  function automatic bit top_unwritten();
    int col;
    bit top_row;
    col     = col_pos;
    top_row = first_row;
    if (col >= eff_width()) begin
      col     = 0;
      top_row = 1'b0;
    end
    return !top_row && !prev_row_valid[col];
  endfunction

  function automatic med_pkg::pixel_out_t codec_predict(input med_pkg::pixel_in_t px);
    int                  w;
    logic [23:0]         top;
    logic [23:0]         sample;
    logic [23:0]         coded;
    logic [23:0]         recon;
    logic [7:0]          guess;
    med_pkg::pixel_out_t res;
    w = eff_width();
    if (px.start_of_image) begin
      col_pos    = 0;
      first_row  = 1'b1;
      left_rgb   = '0;
      upleft_rgb = '0;
    end
    if (col_pos >= w) begin
      col_pos    = 0;
      first_row  = 1'b0;
      left_rgb   = '0;
      upleft_rgb = '0;
    end
    top    = first_row ? 24'h0 : prev_row[col_pos];
    sample = {px.in_red, px.in_green, px.in_blue};
    for (int k = 0; k < 3; k++) begin
      guess = med_estimate(left_rgb[8*k +: 8], top[8*k +: 8], upleft_rgb[8*k +: 8]);
      if (cur_mode == med_pkg::MODE_DECODE) begin
        coded[8*k +: 8] = sample[8*k +: 8] + guess;
        recon[8*k +: 8] = coded[8*k +: 8];
      end else begin
        coded[8*k +: 8] = sample[8*k +: 8] - guess;
        recon[8*k +: 8] = sample[8*k +: 8];
      end
    end
    res.out_red   = coded[23:16];
    res.out_green = coded[15:8];
    res.out_blue  = coded[7:0];
    res.out_alpha = (cur_mode == med_pkg::MODE_DECODE) ? med_pkg::ALPHA_DECODE :
                                                         med_pkg::ALPHA_ENCODE;
    prev_row[col_pos]       = recon;
    prev_row_valid[col_pos] = 1'b1;
    left_rgb   = recon;
    upleft_rgb = top;
    col_pos++;
    if (col_pos >= w) begin
      col_pos    = 0;
      first_row  = 1'b0;
      left_rgb   = '0;
      upleft_rgb = '0;
    end
    return res;
  endfunction

  function automatic script_row_t pixel_row(input bit sof, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b,
                                            input bit typed,
                                            input med_pkg::pixel_out_t want);
    script_row_t row;
    row.is_cfg    = 1'b0;
    row.wr_mode   = 1'b0;
    row.mode_val  = med_pkg::MODE_ENCODE;
    row.wr_width  = 1'b0;
    row.width_val = '0;
    row.px        = '{start_of_image: sof, in_red: r, in_green: g, in_blue: b};
    row.typed     = typed;
    row.want      = want;
    return row;
  endfunction

  function automatic script_row_t cfg_row(input bit wr_mode, input logic mode_val,
                                          input bit wr_width,
                                          input logic [med_pkg::CFG_DATA_W-1:0] width_val);
    script_row_t row;
    row         = pixel_row(1'b0, 8'h00, 8'h00, 8'h00, 1'b0, '0);
    row.is_cfg    = 1'b1;
    row.wr_mode   = wr_mode;
    row.mode_val  = mode_val;
    row.wr_width  = wr_width;
    row.width_val = width_val;
    return row;
  endfunction

  task automatic report_mismatch(input string what, input med_pkg::pixel_out_t want,
                                 input med_pkg::pixel_out_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("Mismatch (%s): expected r %h g %h b %h a %h, got r %h g %h b %h a %h",
               what, want.out_red, want.out_green, want.out_blue, want.out_alpha,
               got.out_red, got.out_green, got.out_blue, got.out_alpha);
    end
  endtask

  task automatic send_pixel(input med_pkg::pixel_in_t px, input bit typed,
                            input med_pkg::pixel_out_t want);
    med_pkg::pixel_out_t predicted;
    if (!px.start_of_image && top_unwritten()) begin
      px.start_of_image = 1'b1;
    end
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predicted = codec_predict(px);
    pending_px_q.push_back(typed ? want : predicted);
    px_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_px_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input bit wr_mode, input logic mode_val, input bit wr_width,
                              input logic [med_pkg::CFG_DATA_W-1:0] width_val);
    if (wr_mode) begin
      cfg_valid <= 1'b1;
      cfg_index <= med_pkg::REG_MODE;
      cfg_data  <= med_pkg::CFG_DATA_W'(mode_val);
      @(posedge clk);
      while (!cfg_ready) begin
        @(posedge clk);
      end
      cur_mode = mode_val;
      cfg_writes++;
    end
    if (wr_width) begin
      cfg_valid <= 1'b1;
      cfg_index <= med_pkg::REG_WIDTH;
      cfg_data  <= width_val;
      @(posedge clk);
      while (!cfg_ready) begin
        @(posedge clk);
      end
      cur_width = width_val;
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_px_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", '0, out_data);
      end else begin
        head_px = pending_px_q.pop_front();
        px_checked++;
        if (out_data.out_red !== head_px.out_red || out_data.out_green !== head_px.out_green ||
            out_data.out_blue !== head_px.out_blue ||
            out_data.out_alpha !== head_px.out_alpha) begin
          report_mismatch("field differs", head_px, out_data);
        end
      end
    end
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding.", pending_px_q.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int                             rand_sent;
    int                             seg_len;
    int                             wsel;
    int                             directed_cnt;
    logic [med_pkg::CFG_DATA_W-1:0] w_pick;
    bit                             smooth;
    bit                             lead;
    med_pkg::rgb_t                  base;
    med_pkg::pixel_in_t             px;

    rand_sent = 0;
    script_q.push_back(pixel_row(1'b0, 8'hff, 8'h00, 8'h80, 1'b1,
                                 '{8'hff, 8'h00, 8'h80, med_pkg::ALPHA_ENCODE}));
    script_q.push_back(pixel_row(1'b0, 8'h01, 8'hfe, 8'h7f, 1'b0, '0));
    script_q.push_back(pixel_row(1'b1, 8'h00, 8'hff, 8'h01, 1'b1,
                                 '{8'h00, 8'hff, 8'h01, med_pkg::ALPHA_ENCODE}));
    script_q.push_back(pixel_row(1'b0, 8'hff, 8'hff, 8'hff, 1'b0, '0));
    script_q.push_back(cfg_row(1'b0, med_pkg::MODE_ENCODE, 1'b1, 13'd3));
    script_q.push_back(pixel_row(1'b0, 8'h80, 8'h80, 8'h80, 1'b0, '0));
    script_q.push_back(pixel_row(1'b0, 8'h12, 8'h34, 8'h56, 1'b0, '0));
    script_q.push_back(pixel_row(1'b0, 8'hff, 8'h00, 8'hff, 1'b0, '0));
    script_q.push_back(pixel_row(1'b0, 8'h00, 8'hff, 8'h00, 1'b0, '0));
    script_q.push_back(pixel_row(1'b0, 8'hab, 8'hcd, 8'hef, 1'b0, '0));
    script_q.push_back(cfg_row(1'b1, med_pkg::MODE_DECODE, 1'b0, '0));
    script_q.push_back(pixel_row(1'b1, 8'h7f, 8'h80, 8'h01, 1'b1,
                                 '{8'h7f, 8'h80, 8'h01, med_pkg::ALPHA_DECODE}));
    script_q.push_back(pixel_row(1'b0, 8'hff, 8'hff, 8'hff, 1'b0, '0));
    script_q.push_back(pixel_row(1'b0, 8'h01, 8'h01, 8'h01, 1'b0, '0));
    script_q.push_back(pixel_row(1'b0, 8'h80, 8'h7f, 8'h00, 1'b0, '0));
    script_q.push_back(cfg_row(1'b0, med_pkg::MODE_DECODE, 1'b1, 13'd0));
    script_q.push_back(pixel_row(1'b0, 8'h00, 8'h00, 8'h00, 1'b0, '0));
    script_q.push_back(pixel_row(1'b0, 8'hff, 8'hff, 8'hff, 1'b0, '0));
    script_q.push_back(cfg_row(1'b0, med_pkg::MODE_DECODE, 1'b1, 13'd8191));
    script_q.push_back(pixel_row(1'b1, 8'h00, 8'h00, 8'h00, 1'b1,
                                 '{8'h00, 8'h00, 8'h00, med_pkg::ALPHA_DECODE}));
    script_q.push_back(pixel_row(1'b0, 8'hff, 8'h00, 8'hff, 1'b0, '0));
    script_q.push_back(cfg_row(1'b1, med_pkg::MODE_ENCODE, 1'b1, 13'd2));
    script_q.push_back(pixel_row(1'b0, 8'hff, 8'hff, 8'hff, 1'b0, '0));
    script_q.push_back(pixel_row(1'b0, 8'h00, 8'h00, 8'h00, 1'b0, '0));
    script_q.push_back(pixel_row(1'b0, 8'h7f, 8'h80, 8'h7f, 1'b0, '0));
    script_q.push_back(pixel_row(1'b1, 8'hff, 8'hff, 8'hff, 1'b1,
                                 '{8'hff, 8'hff, 8'hff, med_pkg::ALPHA_ENCODE}));
    script_q.push_back(pixel_row(1'b0, 8'h00, 8'h00, 8'h00, 1'b0, '0));
    script_q.push_back(pixel_row(1'b0, 8'hff, 8'hff, 8'hff, 1'b0, '0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script_q[i]) begin
      if (script_q[i].is_cfg) begin
        drain_results();
        program_regs(script_q[i].wr_mode, script_q[i].mode_val,
                     script_q[i].wr_width, script_q[i].width_val);
      end else begin
        send_pixel(script_q[i].px, script_q[i].typed, script_q[i].want);
      end
    end
    directed_cnt = px_sent;

    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct   = (phase == 0) ? 17 : (phase == 1) ? 87 : 0;
      out_stall_pct = (phase == 0) ? 87 : (phase == 1) ? 17 : 0;
      while (rand_sent < RAND_PER_PHASE * (phase + 1)) begin
        if ($urandom_range(2) != 0) begin
          drain_results();
          wsel = $urandom_range(99);
          if (wsel < 5) begin
            w_pick = '0;
          end else if (wsel < 10) begin
            w_pick = 13'd1;
          end else if (wsel < 14) begin
            w_pick = 13'(med_pkg::MAX_WIDTH_DEF);
          end else if (wsel < 17) begin
            w_pick = 13'd8191;
          end else if (wsel < 20) begin
            w_pick = 13'($urandom_range(4097, 8191));
          end else if (wsel < 30) begin
            w_pick = 13'($urandom_range(25, 300));
          end else begin
            w_pick = 13'($urandom_range(2, 24));
          end
          program_regs($urandom_range(3) != 0, 1'($urandom_range(1)),
                       $urandom_range(3) != 0, w_pick);
        end
        seg_len = $urandom_range(4, 48);
        smooth  = ($urandom_range(1) == 1);
        lead    = ($urandom_range(99) < 85);
        base    = 24'($urandom);
        for (int i = 0; i < seg_len; i++) begin
          if (smooth && i != 0) begin
            base.red   = base.red + 8'($urandom_range(6)) - 8'd3;
            base.green = base.green + 8'($urandom_range(6)) - 8'd3;
            base.blue  = base.blue + 8'($urandom_range(6)) - 8'd3;
          end else begin
            base = 24'($urandom);
          end
          px.start_of_image = (i == 0 && lead) || ($urandom_range(99) < 3);
          px.in_red         = base.red;
          px.in_green       = base.green;
          px.in_blue        = base.blue;
          send_pixel(px, 1'b0, '0);
          rand_sent++;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_px_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    $display("Ran %0d directed and %0d random pixel transactions; %0d results compared.",
             directed_cnt, rand_sent, px_checked);
    $display("Made %0d register writes over both modes and widths from 0 up to 8191.",
             cfg_writes);
    if (mismatch_cnt == 0 && pending_px_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
